// File: src/ocsd_pkg.sv
`default_nettype none

package ocsd_pkg;

  // Decoded instruction class, in match priority order.
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_CLR     = 4'd1,
    OP_LDI     = 4'd2,
    OP_LD_XINC = 4'd3,
    OP_LD_YINC = 4'd4,
    OP_LD_XDEC = 4'd5,
    OP_CPI     = 4'd6,
    OP_BRNE    = 4'd7,
    OP_SBIW    = 4'd8,
    OP_CP      = 4'd9,
    OP_MOV     = 4'd10,
    OP_INC     = 4'd11,
    OP_DEC     = 4'd12,
    OP_UNKNOWN = 4'd13
  } ocsd_op_e;

  localparam int unsigned InstrWidth = 16;

  // Opcode masks.
  localparam logic [15:0] MaskRdOp   = 16'hFE00;
  localparam logic [15:0] MaskHiNib  = 16'hF000;
  localparam logic [15:0] MaskRdSub  = 16'hFE0F;
  localparam logic [15:0] MaskBranch = 16'hFC07;
  localparam logic [15:0] MaskByte   = 16'hFF00;
  localparam logic [15:0] MaskRdRr   = 16'hFC00;

  // Opcode match values.
  localparam logic [15:0] PatNop    = 16'h0000;
  localparam logic [15:0] PatClr    = 16'h2400;
  localparam logic [15:0] PatLdi    = 16'hE000;
  localparam logic [15:0] PatLdXinc = 16'h900D;
  localparam logic [15:0] PatLdYinc = 16'h9009;
  localparam logic [15:0] PatLdXdec = 16'h900E;
  localparam logic [15:0] PatCpi    = 16'h3000;
  localparam logic [15:0] PatBrne   = 16'hF401;
  localparam logic [15:0] PatSbiw   = 16'h9700;
  localparam logic [15:0] PatCp     = 16'h1400;
  localparam logic [15:0] PatMov    = 16'h2C00;
  localparam logic [15:0] PatInc    = 16'h9403;
  localparam logic [15:0] PatDec    = 16'h940A;

  // Decoded result; the first field sits in the highest bits.
  typedef struct packed {
    logic signed [7:0] branch_offset;
    logic [7:0]        imm_value;
    logic [4:0]        src_reg;
    logic [4:0]        dest_reg;
    ocsd_op_e          op_kind;
  } ocsd_result_t;

  localparam int unsigned ResultWidth = $bits(ocsd_result_t);
  localparam int unsigned OutDataWidth = ((ResultWidth + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: src/ocsd_decode.sv
`default_nettype none

module ocsd_decode (
  input  logic [15:0]           instr_word_i,
  output ocsd_pkg::ocsd_result_t result_o
);
  import ocsd_pkg::*;

  logic [15:0] w;
  logic [6:0]  k7;
  logic [4:0]  rd5;
  logic [4:0]  rd_hi;
  logic [4:0]  rr5;
  logic [7:0]  imm8;

  assign w     = instr_word_i;
  assign k7    = w[9:3];
  assign rd5   = w[8:4];
  assign rd_hi = {1'b1, w[7:4]};
  assign rr5   = {w[9], w[3:0]};
  assign imm8  = {w[11:8], w[3:0]};

  // Priority chain: the first matching pattern wins.
  always_comb begin
    result_o = '0;
    result_o.op_kind = OP_UNKNOWN;
    if (w == PatNop) begin
      result_o.op_kind = OP_NOP;
    end else if ((w & MaskRdOp) == PatClr) begin
      result_o.op_kind  = OP_CLR;
      result_o.dest_reg = rd5;
    end else if ((w & MaskHiNib) == PatLdi) begin
      result_o.op_kind   = OP_LDI;
      result_o.dest_reg  = rd_hi;
      result_o.imm_value = imm8;
    end else if ((w & MaskRdSub) == PatLdXinc) begin
      result_o.op_kind  = OP_LD_XINC;
      result_o.dest_reg = rd5;
    end else if ((w & MaskRdSub) == PatLdYinc) begin
      result_o.op_kind  = OP_LD_YINC;
      result_o.dest_reg = rd5;
    end else if ((w & MaskRdSub) == PatLdXdec) begin
      result_o.op_kind  = OP_LD_XDEC;
      result_o.dest_reg = rd5;
    end else if ((w & MaskHiNib) == PatCpi) begin
      result_o.op_kind   = OP_CPI;
      result_o.dest_reg  = rd_hi;
      result_o.imm_value = imm8;
    end else if ((w & MaskBranch) == PatBrne) begin
      // Sign-extend the seven-bit offset, then add one.
      result_o.op_kind       = OP_BRNE;
      result_o.branch_offset = $signed({k7[6], k7}) + 8'sd1;
    end else if ((w & MaskByte) == PatSbiw) begin
      result_o.op_kind   = OP_SBIW;
      result_o.dest_reg  = {2'b11, w[5:4], 1'b0};
      result_o.imm_value = {2'b00, w[7:6], w[3:0]};
    end else if ((w & MaskRdRr) == PatCp) begin
      result_o.op_kind  = OP_CP;
      result_o.dest_reg = rd5;
      result_o.src_reg  = rr5;
    end else if ((w & MaskRdRr) == PatMov) begin
      result_o.op_kind  = OP_MOV;
      result_o.dest_reg = rd5;
      result_o.src_reg  = rr5;
    end else if ((w & MaskRdSub) == PatInc) begin
      result_o.op_kind  = OP_INC;
      result_o.dest_reg = rd5;
    end else if ((w & MaskRdSub) == PatDec) begin
      result_o.op_kind  = OP_DEC;
      result_o.dest_reg = rd5;
    end
  end

endmodule

`default_nettype wire

// File: src/mcu_opcode_subset_decoder_top.sv
// Opcode subset decoder.
// A 16-bit instruction word enters on the slave stream (s_axis_*); each word
// produces exactly one decoded result on the master stream (m_axis_*). The
// result carries the instruction class, destination and source register
// numbers, the immediate constant and the adjusted branch offset. Fields that
// do not apply to the decoded class are zero, and unrecognized words report
// the unknown class with all other fields zero.
// A word accepted on the slave stream is captured in the input register,
// decoded by a single combinational pass, and its result is registered in
// the output register, from which it is presented on the master stream.
// Throughput is one transaction per cycle for as long as the receiver takes
// results. When the receiver stalls, the output register holds its result
// and the input register can still take one more word; only when both are
// full does s_axis_tready_o drop. No result is lost or repeated across
// stalls. Reset clears both valid flags, so no result is presented after
// reset; the word and result data registers are not reset.
`default_nettype none

module mcu_opcode_subset_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] instr_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] op_kind, [8:4] dest_reg, [13:9] src_reg, [21:14] imm_value,
  // [29:22] branch_offset, [31:30] zero
  output logic [31:0] m_axis_tdata_o
);
  import ocsd_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [15:0]  word_q;
  logic         out_valid_q, out_valid_d;
  ocsd_result_t res_q;
  ocsd_result_t dec_res;
  logic         in_take;
  logic         out_free;
  logic         advance;

  ocsd_decode u_decode (
    .instr_word_i(word_q),
    .result_o    (dec_res)
  );

  // The output slot is free when empty or when its result leaves this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      word_q <= s_axis_tdata_i;
    end
    if (advance) begin
      res_q <= dec_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataWidth - ResultWidth){1'b0}}, res_q};

endmodule

`default_nettype wire

// File: tb/opcode_decode_checker.sv
module opcode_decode_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [15:0]        s_axis_tdata_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [31:0]        m_axis_tdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        words_checked_o,
  output logic [13:0]        kinds_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ocsd_pkg::*;

  typedef struct {
    logic [15:0]  word;
    ocsd_result_t decoded;
  } pending_decode_t;

  pending_decode_t pending_decodes[$];

  // Priority decode: the first matching pattern wins, so the casez order matters.
  function automatic ocsd_result_t decode_instr(input logic [15:0] w);
    ocsd_result_t r;
    r = '0;
    r.op_kind = OP_UNKNOWN;
    casez (w)
      16'b0000_0000_0000_0000: r.op_kind = OP_NOP;
      16'b0010_010?_????_????: begin
        r.op_kind  = OP_CLR;
        r.dest_reg = w[8:4];
      end
      16'b1110_????_????_????: begin
        r.op_kind   = OP_LDI;
        r.dest_reg  = {1'b1, w[7:4]};
        r.imm_value = {w[11:8], w[3:0]};
      end
      16'b1001_000?_????_1101: begin
        r.op_kind  = OP_LD_XINC;
        r.dest_reg = w[8:4];
      end
      16'b1001_000?_????_1001: begin
        r.op_kind  = OP_LD_YINC;
        r.dest_reg = w[8:4];
      end
      16'b1001_000?_????_1110: begin
        r.op_kind  = OP_LD_XDEC;
        r.dest_reg = w[8:4];
      end
      16'b0011_????_????_????: begin
        r.op_kind   = OP_CPI;
        r.dest_reg  = {1'b1, w[7:4]};
        r.imm_value = {w[11:8], w[3:0]};
      end
      16'b1111_01??_????_?001: begin
        r.op_kind       = OP_BRNE;
        r.branch_offset = $signed({w[9], w[9:3]}) + 8'sd1;
      end
      16'b1001_0111_????_????: begin
        r.op_kind   = OP_SBIW;
        r.dest_reg  = {2'b11, w[5:4], 1'b0};
        r.imm_value = {2'b00, w[7:6], w[3:0]};
      end
      16'b0001_01??_????_????: begin
        r.op_kind  = OP_CP;
        r.dest_reg = w[8:4];
        r.src_reg  = {w[9], w[3:0]};
      end
      16'b0010_11??_????_????: begin
        r.op_kind  = OP_MOV;
        r.dest_reg = w[8:4];
        r.src_reg  = {w[9], w[3:0]};
      end
      16'b1001_010?_????_0011: begin
        r.op_kind  = OP_INC;
        r.dest_reg = w[8:4];
      end
      16'b1001_010?_????_1010: begin
        r.op_kind  = OP_DEC;
        r.dest_reg = w[8:4];
      end
      default: r = r;
    endcase
    return r;
  endfunction

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    words_checked_o = 0;
    kinds_seen_o    = '0;
  end

  always @(posedge clk_i) begin
    pending_decode_t exp_item;
    ocsd_result_t    got;
    logic            bad;
    if (rst_ni) begin
      // Results leave before the word accepted at this same edge can produce one.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[29:0];
        if (pending_decodes.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10)
            $display("%0t: result %h arrived with no word outstanding", $realtime,
                     m_axis_tdata_i);
        end else begin
          exp_item = pending_decodes.pop_front();
          bad = (got.op_kind !== exp_item.decoded.op_kind) ||
                (got.dest_reg !== exp_item.decoded.dest_reg) ||
                (got.src_reg !== exp_item.decoded.src_reg) ||
                (got.imm_value !== exp_item.decoded.imm_value) ||
                (got.branch_offset !== exp_item.decoded.branch_offset) ||
                (m_axis_tdata_i[31:30] !== 2'b00);
          words_checked_o = words_checked_o + 1;
          kinds_seen_o[exp_item.decoded.op_kind] = 1'b1;
          if (bad) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display({"%0t: word %h: expected kind %0d rd %0d rr %0d imm %0d ofs %0d,",
                        " got kind %0d rd %0d rr %0d imm %0d ofs %0d pad %b"},
                       $realtime, exp_item.word,
                       exp_item.decoded.op_kind, exp_item.decoded.dest_reg,
                       exp_item.decoded.src_reg, exp_item.decoded.imm_value,
                       exp_item.decoded.branch_offset,
                       got.op_kind, got.dest_reg, got.src_reg, got.imm_value,
                       got.branch_offset, m_axis_tdata_i[31:30]);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        exp_item.word    = s_axis_tdata_i;
        exp_item.decoded = decode_instr(s_axis_tdata_i);
        pending_decodes.push_back(exp_item);
      end
      pending_o = pending_decodes.size();
    end
  end

endmodule

// File: tb/testbench.sv
// The testbench top only produces traffic and reports the verdict. All
// prediction and comparison happens in the checker instance that sits next
// to the decoder and snoops both stream interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ocsd_pkg::*;

  // Cycles without any transaction on either side before the run is declared hung.
  localparam int unsigned QuietLimit = 1000;
  // Length of the deliberate receiver hold-off that backs the pipeline up.
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned WordsPerPhase = 356;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [15:0] instr_word
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [3:0] op_kind, [8:4] dest_reg, [13:9] src_reg,
                                 // [21:14] imm_value, [29:22] branch_offset

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  logic [13:0] kinds_seen;

  // Throttling knobs, in percent of cycles.
  int unsigned idle_pct;
  int unsigned stall_pct;
  logic        hold_active;
  int unsigned quiet_cycles;
  event        hold_go;

  mcu_opcode_subset_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  opcode_decode_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .kinds_seen_o    (kinds_seen)
  );

  // 2 ns clock: one nanosecond high, one low.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Every input starts from a known value before the first edge.
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_active     = 1'b0;
  end

  // The receiver decides its ready at each falling edge. During a hold-off it
  // refuses everything; otherwise it stalls at the rate of the current phase.
  always @(negedge clk_i) begin
    m_axis_tready_i <= !hold_active && ($urandom_range(99) >= stall_pct);
  end

  // The hold-off runs in its own process and counts rising edges, so the
  // receiver sees a stable flag at every falling edge. The sender keeps
  // offering words meanwhile, which fills both pipeline registers and forces
  // s_axis_tready_o low.
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk_i);
      hold_active = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_active = 1'b0;
    end
  end

  // Watchdog: any cycle with a transaction on either side resets the count.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no transaction for %0d cycles", QuietLimit);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one instruction word, starting and ending at a falling edge. The
  // idle gaps drop tvalid on their own falling edges, so tvalid is never
  // lowered and raised within the same time step.
  task automatic send_word(input logic [15:0] w);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Builds a word that matches the given class, with every don't-care bit
  // random. Words drawn this way can still be shadowed by an earlier pattern,
  // which exercises the priority order as well.
  function automatic logic [15:0] word_of_kind(input ocsd_op_e kind);
    logic [15:0] r;
    r = 16'($urandom);
    case (kind)
      OP_NOP:     return 16'h0000;
      OP_CLR:     return (r & ~16'hFE00) | 16'h2400;
      OP_LDI:     return (r & ~16'hF000) | 16'hE000;
      OP_LD_XINC: return (r & ~16'hFE0F) | 16'h900D;
      OP_LD_YINC: return (r & ~16'hFE0F) | 16'h9009;
      OP_LD_XDEC: return (r & ~16'hFE0F) | 16'h900E;
      OP_CPI:     return (r & ~16'hF000) | 16'h3000;
      OP_BRNE:    return (r & ~16'hFC07) | 16'hF401;
      OP_SBIW:    return (r & ~16'hFF00) | 16'h9700;
      OP_CP:      return (r & ~16'hFC00) | 16'h1400;
      OP_MOV:     return (r & ~16'hFC00) | 16'h2C00;
      OP_INC:     return (r & ~16'hFE0F) | 16'h9403;
      OP_DEC:     return (r & ~16'hFE0F) | 16'h940A;
      default:    return r;
    endcase
  endfunction

  // Roughly two thirds of the random words target a known class; the rest are
  // fully random and mostly decode as unknown.
  task automatic send_random_words(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 65)
        send_word(word_of_kind(ocsd_op_e'($urandom_range(12))));
      else
        send_word(16'($urandom));
    end
  endtask

  // Directed words: field extremes of every class, the branch offset at both
  // ends of its range, a clear whose source bits differ from its destination,
  // and words that sit just beside a pattern.
  logic [15:0] directed_words[25] = '{
    16'h0000, 16'hFFFF, 16'h0001,              // nop, all ones, just off nop
    16'h2400, 16'h25F3,                        // clr, source bits unlike dest
    16'hE000, 16'hEFFF,                        // ldi extremes
    16'h900D, 16'h91FD, 16'h9009, 16'h91F9,    // ld x+, ld y+
    16'h900E, 16'h91FE,                        // ld -x
    16'h3000, 16'h3FFF,                        // cpi extremes
    16'hF5F9, 16'hF601, 16'hF7F9,              // brne: +64, -63, 0
    16'h9700, 16'h97FF,                        // sbiw extremes
    16'h17FF, 16'h2FFF,                        // cp, mov with all operand bits set
    16'h95F3, 16'h940A,                        // inc, dec
    16'h9400                                   // beside inc, unknown
  };

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase without any throttling: directed words, then a receiver hold-off
    // while the sender streams back to back, then the rest of the phase.
    foreach (directed_words[i]) send_word(directed_words[i]);
    -> hold_go;
    send_random_words(WordsPerPhase);

    // Sender mostly idle.
    idle_pct  = 80;
    stall_pct = 0;
    send_random_words(WordsPerPhase);

    // Receiver mostly stalling.
    idle_pct  = 0;
    stall_pct = 80;
    send_random_words(WordsPerPhase);

    // Both sides throttle a third of the time.
    idle_pct  = 33;
    stall_pct = 33;
    send_random_words(WordsPerPhase);

    s_axis_tvalid_i <= 1'b0;
    stall_pct = 0;

    // Drain every outstanding result, then give the two-stage pipeline a few
    // more cycles in which a stray result would be caught.
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d decoded words under four throttling phases and a %0d-cycle hold-off,",
             words_checked, HoldCycles);
    $display("with %0d of 14 instruction classes observed.", $countones(kinds_seen));
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
